// ===== src/vwm_pkg.sv =====
// Shared types and constants for the voltage window monitor.
package vwm_pkg;

  localparam int unsigned CFG_INDEX_WIDTH = 3;

  typedef enum logic [1:0] {
    QS_INVALID  = 2'd0,
    QS_ENTERING = 2'd1,
    QS_VALID    = 2'd2,
    QS_EXITING  = 2'd3
  } qual_state_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_INSTANT_LOW  = 3'd0,
    REG_INSTANT_HIGH = 3'd1,
    REG_VALID_LOW    = 3'd2,
    REG_VALID_HIGH   = 3'd3,
    REG_EXIT_LOW     = 3'd4,
    REG_EXIT_HIGH    = 3'd5,
    REG_ENTER_DELAY  = 3'd6,
    REG_EXIT_DELAY   = 3'd7
  } cfg_reg_t;

endpackage

// ===== src/vwm_ifs.sv =====
// Stream and configuration interfaces of the voltage window monitor.
interface vwm_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_voltage;
  logic        [TIME_WIDTH-1:0]   timestamp;

  modport source (output valid, output sample_voltage, output timestamp, input ready);
  modport sink   (input valid, input sample_voltage, input timestamp, output ready);
endinterface

interface vwm_out_if #(
  parameter int unsigned TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            qualifier_state;
  logic                  valid_flag;
  logic [TIME_WIDTH-1:0] valid_duration;
  logic [TIME_WIDTH-1:0] state_duration;

  modport source (output valid, output qualifier_state, output valid_flag,
                  output valid_duration, output state_duration, input ready);
  modport sink   (input valid, input qualifier_state, input valid_flag,
                  input valid_duration, input state_duration, output ready);
endinterface

interface vwm_cfg_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            index;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/vwm_cfg_regs.sv =====
// Threshold and delay register file.
module vwm_cfg_regs #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  vwm_cfg_if.sink                        cfg,
  output logic signed [SAMPLE_WIDTH-1:0] instant_low_limit,
  output logic signed [SAMPLE_WIDTH-1:0] instant_high_limit,
  output logic signed [SAMPLE_WIDTH-1:0] valid_low_bound,
  output logic signed [SAMPLE_WIDTH-1:0] valid_high_bound,
  output logic signed [SAMPLE_WIDTH-1:0] exit_low_limit,
  output logic signed [SAMPLE_WIDTH-1:0] exit_high_limit,
  output logic        [TIME_WIDTH-1:0]   enter_delay,
  output logic        [TIME_WIDTH-1:0]   exit_delay
);
  import vwm_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  logic signed [SAMPLE_WIDTH-1:0] wr_sample;
  logic        [TIME_WIDTH-1:0]   wr_time;

  assign cfg.ready = 1'b1;
  assign wr_sample = cfg.data[SAMPLE_WIDTH-1:0];
  assign wr_time   = cfg.data[TIME_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      instant_low_limit  <= '0;
      instant_high_limit <= SAMPLE_MAX;
      valid_low_bound    <= '0;
      valid_high_bound   <= SAMPLE_MAX;
      exit_low_limit     <= '0;
      exit_high_limit    <= SAMPLE_MAX;
      enter_delay        <= '0;
      exit_delay         <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_INSTANT_LOW:  instant_low_limit  <= wr_sample;
        REG_INSTANT_HIGH: instant_high_limit <= wr_sample;
        REG_VALID_LOW:    valid_low_bound    <= wr_sample;
        REG_VALID_HIGH:   valid_high_bound   <= wr_sample;
        REG_EXIT_LOW:     exit_low_limit     <= wr_sample;
        REG_EXIT_HIGH:    exit_high_limit    <= wr_sample;
        REG_ENTER_DELAY:  enter_delay        <= wr_time;
        REG_EXIT_DELAY:   exit_delay         <= wr_time;
      endcase
    end
  end

endmodule

// ===== src/vwm_qualifier.sv =====
// Qualifier state machine with result register.
module vwm_qualifier #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_voltage,
  input  logic        [TIME_WIDTH-1:0]   timestamp,
  input  logic signed [SAMPLE_WIDTH-1:0] instant_low_limit,
  input  logic signed [SAMPLE_WIDTH-1:0] instant_high_limit,
  input  logic signed [SAMPLE_WIDTH-1:0] valid_low_bound,
  input  logic signed [SAMPLE_WIDTH-1:0] valid_high_bound,
  input  logic signed [SAMPLE_WIDTH-1:0] exit_low_limit,
  input  logic signed [SAMPLE_WIDTH-1:0] exit_high_limit,
  input  logic        [TIME_WIDTH-1:0]   enter_delay,
  input  logic        [TIME_WIDTH-1:0]   exit_delay,
  output logic [1:0]                     qualifier_state,
  output logic                           valid_flag,
  output logic [TIME_WIDTH-1:0]          valid_duration,
  output logic [TIME_WIDTH-1:0]          state_duration
);
  import vwm_pkg::*;

  qual_state_t           state, state_next;
  logic [TIME_WIDTH-1:0] start_time, start_time_next;
  logic                  valid_bit, valid_bit_next;
  logic [TIME_WIDTH-1:0] valid_time, valid_time_next;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  instant, in_window, beyond_exit;

  assign elapsed     = timestamp - start_time;
  assign instant     = (sample_voltage <= instant_low_limit) ||
                       (sample_voltage >= instant_high_limit);
  assign in_window   = (sample_voltage > valid_low_bound) &&
                       (sample_voltage < valid_high_bound);
  assign beyond_exit = (sample_voltage <= exit_low_limit) ||
                       (sample_voltage >= exit_high_limit);

  always_comb begin
    state_next      = state;
    start_time_next = start_time;
    valid_bit_next  = valid_bit;
    valid_time_next = valid_bit ? elapsed : valid_time;
    if (instant) begin
      if (state != QS_INVALID) begin
        state_next      = QS_INVALID;
        start_time_next = timestamp;
        valid_bit_next  = 1'b0;
        valid_time_next = '0;
      end
    end else begin
      unique case (state)
        QS_INVALID: begin
          if (in_window) begin
            state_next      = QS_ENTERING;
            start_time_next = timestamp;
          end
        end
        QS_ENTERING: begin
          if (!in_window) begin
            state_next      = QS_INVALID;
            start_time_next = timestamp;
          end else if (elapsed >= enter_delay) begin
            state_next      = QS_VALID;
            valid_bit_next  = 1'b1;
            start_time_next = timestamp;
          end
        end
        QS_VALID: begin
          if (beyond_exit) begin
            state_next      = QS_EXITING;
            start_time_next = timestamp;
          end
        end
        QS_EXITING: begin
          if (!in_window && beyond_exit) begin
            // start time kept: invalid keeps counting from start of exiting
            if (elapsed >= exit_delay) begin
              state_next      = QS_INVALID;
              valid_bit_next  = 1'b0;
              valid_time_next = '0;
            end
          end else begin
            state_next      = QS_VALID;
            start_time_next = timestamp;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= QS_INVALID;
      start_time <= '0;
      valid_bit  <= 1'b0;
      valid_time <= '0;
    end else if (step) begin
      state      <= state_next;
      start_time <= start_time_next;
      valid_bit  <= valid_bit_next;
      valid_time <= valid_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      qualifier_state <= state_next;
      valid_flag      <= valid_bit_next;
      valid_duration  <= valid_time_next;
      state_duration  <= elapsed;
    end
  end

endmodule

// ===== src/voltage_window_monitor.sv =====
// Top level of the voltage window monitor.
//
//   channel   dir  payload                                                    transfer
//   samples   in   sample_voltage, timestamp                                  valid & ready
//   results   out  qualifier_state, valid_flag, valid_duration, state_duration valid & ready
//   cfg       in   index, data                                                valid & ready
//
// One sample per cycle while results are not stalled; stages: input register, then result register.
// The qualifier state updates in the same cycle as the result register loads.
// A stalled result holds both stages; samples are taken while the input stage is free.
// Reset restores the register defaults and the invalid state. cfg is always ready.
module voltage_window_monitor #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input logic       clk,
  input logic       rst,
  vwm_in_if.sink    samples,
  vwm_out_if.source results,
  vwm_cfg_if.sink   cfg
);
  import vwm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] instant_low_limit, instant_high_limit;
  logic signed [SAMPLE_WIDTH-1:0] valid_low_bound, valid_high_bound;
  logic signed [SAMPLE_WIDTH-1:0] exit_low_limit, exit_high_limit;
  logic        [TIME_WIDTH-1:0]   enter_delay, exit_delay;

  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic        [TIME_WIDTH-1:0]   s1_timestamp;
  logic                           out_valid;
  logic                           advance, step, load;

  assign advance       = !out_valid || results.ready;
  assign step          = s1_valid && advance;
  assign samples.ready = !s1_valid || advance;
  assign load          = samples.valid && samples.ready;
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (samples.ready) s1_valid <= samples.valid;
      if (step) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_sample    <= samples.sample_voltage;
      s1_timestamp <= samples.timestamp;
    end
  end

  vwm_cfg_regs #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_cfg_regs (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .instant_low_limit (instant_low_limit),
    .instant_high_limit(instant_high_limit),
    .valid_low_bound   (valid_low_bound),
    .valid_high_bound  (valid_high_bound),
    .exit_low_limit    (exit_low_limit),
    .exit_high_limit   (exit_high_limit),
    .enter_delay       (enter_delay),
    .exit_delay        (exit_delay)
  );

  vwm_qualifier #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_qualifier (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .sample_voltage    (s1_sample),
    .timestamp         (s1_timestamp),
    .instant_low_limit (instant_low_limit),
    .instant_high_limit(instant_high_limit),
    .valid_low_bound   (valid_low_bound),
    .valid_high_bound  (valid_high_bound),
    .exit_low_limit    (exit_low_limit),
    .exit_high_limit   (exit_high_limit),
    .enter_delay       (enter_delay),
    .exit_delay        (exit_delay),
    .qualifier_state   (results.qualifier_state),
    .valid_flag        (results.valid_flag),
    .valid_duration    (results.valid_duration),
    .state_duration    (results.state_duration)
  );

endmodule
